// ===== rtl/core/fbc_pkg.sv =====
// Shared types and constants for the frustum box cull block.
`default_nettype none

package fbc_pkg;

    localparam int MAX_PLANES     = 6;
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_W        = 16;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 64;
    localparam int COUNT_W        = 17;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int DIST_W         = PROD_W + 1;
    localparam int FRAC_BITS      = 14;
    localparam int IN_TDATA_W     = 112;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [2:0][COORD_W-1:0] t_vec3;

    // bits 15:0 nx, 31:16 ny, 47:32 nz, 63:48 d
    typedef struct packed {
        logic [COORD_W-1:0] d;
        t_vec3              n;
    } t_plane;

    typedef struct packed {
        logic ld1;
        logic ld2;
    } t_stage_en;

    typedef struct packed {
        logic all_behind;
        logic any_behind;
    } t_plane_flags;

    typedef enum logic [1:0] {
        CONT_NONE    = 2'd0,
        CONT_PARTIAL = 2'd1,
        CONT_WHOLE   = 2'd2
    } t_cont;

endpackage

`default_nettype wire

// ===== rtl/core/fbc_plane_regs.sv =====
// Plane configuration registers written through the plain write port.
`default_nettype none

module fbc_plane_regs #(
    parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [fbc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [fbc_pkg::CFG_DW-1:0] i_cfg_wdata,
    output fbc_pkg::t_plane                 o_plane [PLANE_COUNT]
);
    import fbc_pkg::*;

    t_plane r_plane [PLANE_COUNT];

    // writes to indexes with no stored plane fall through
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_we && i_cfg_addr == CFG_AW'(p)) begin
                r_plane[p] <= t_plane'(i_cfg_wdata);
            end
        end
    end

    assign o_plane = r_plane;

endmodule

`default_nettype wire

// ===== rtl/core/fbc_plane_unit.sv =====
// One plane test: nearest/farthest corner products, then distance sign flags.
`default_nettype none

module fbc_plane_unit (
    input  wire logic               i_clk,
    input  wire fbc_pkg::t_plane    i_plane,
    input  wire fbc_pkg::t_vec3     i_lo,
    input  wire fbc_pkg::t_vec3     i_hi,
    input  wire fbc_pkg::t_stage_en i_en,
    output fbc_pkg::t_plane_flags   o_flags
);
    import fbc_pkg::*;

    logic signed [COORD_W-1:0] big    [3];
    logic signed [COORD_W-1:0] sml    [3];
    logic signed [COORD_W-1:0] c_far  [3];
    logic signed [COORD_W-1:0] c_near [3];
    logic signed [PROD_W-1:0]  n_pmax [3];
    logic signed [PROD_W-1:0]  n_pmin [3];
    logic signed [PROD_W-1:0]  r_pmax [3];
    logic signed [PROD_W-1:0]  r_pmin [3];
    logic signed [DIST_W-1:0]  doff;
    logic signed [DIST_W-1:0]  sum_max;
    logic signed [DIST_W-1:0]  sum_min;
    t_plane_flags              r_flags;

    // per axis: pick the coordinate that maximizes / minimizes n*coord,
    // valid for inverted boxes too since both coords are compared
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if ($signed(i_hi[a]) >= $signed(i_lo[a])) begin
                big[a] = $signed(i_hi[a]);
                sml[a] = $signed(i_lo[a]);
            end else begin
                big[a] = $signed(i_lo[a]);
                sml[a] = $signed(i_hi[a]);
            end
            c_far[a]  = i_plane.n[a][COORD_W-1] ? sml[a] : big[a];
            c_near[a] = i_plane.n[a][COORD_W-1] ? big[a] : sml[a];
            n_pmax[a] = $signed(i_plane.n[a]) * c_far[a];
            n_pmin[a] = $signed(i_plane.n[a]) * c_near[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_pmax <= n_pmax;
            r_pmin <= n_pmin;
        end
    end

    // offset d in coordinate units, scaled to Q.14
    assign doff = $signed({{(DIST_W-COORD_W-FRAC_BITS){i_plane.d[COORD_W-1]}},
                           i_plane.d, {FRAC_BITS{1'b0}}});

    assign sum_max = DIST_W'(r_pmax[0]) + DIST_W'(r_pmax[1]) + DIST_W'(r_pmax[2]) + doff;
    assign sum_min = DIST_W'(r_pmin[0]) + DIST_W'(r_pmin[1]) + DIST_W'(r_pmin[2]) + doff;

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_flags.all_behind <= sum_max[DIST_W-1];
            r_flags.any_behind <= sum_min[DIST_W-1];
        end
    end

    assign o_flags = r_flags;

endmodule

`default_nettype wire

// ===== rtl/core/frustum_box_cull.sv =====
// Top level of the frustum box cull block.
// Tests axis-aligned boxes against PLANE_COUNT planes and streams one
// result item per box. Each box passes an input register, a product stage
// (one 16x16 multiply per axis for the nearest and farthest corner of every
// plane), a distance-sign stage and the result register; a new box is taken
// every cycle unless the output stalls. Each stage loads whenever it is
// empty or its successor moves, so bubbles close up and input is still
// taken while a result waits if a stage is empty. A box is rejected when
// its farthest corner lies behind some plane, whole when its nearest corner
// lies behind none. The visible count saturates and clears after a result
// marked last. Planes must be written only while idle; this is not enforced.
`default_nettype none

module frustum_box_cull #(
    parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fbc_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  wire logic [fbc_pkg::CFG_DW-1:0]      i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // box_index, min_x, min_y, min_z, max_x, max_y, max_z
    input  wire logic [fbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // index_out, containment, visible, visible_count, zero pad
    output logic [fbc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import fbc_pkg::*;

    t_plane       planes [PLANE_COUNT];
    t_plane_flags flags  [PLANE_COUNT];
    t_stage_en    en;

    logic ld0;
    logic ld3;

    logic                r_v0, r_v1, r_v2, r_v3;
    logic                r_last0, r_last1, r_last2, r_last3;
    logic [COORD_W-1:0]  r_idx0, r_idx1, r_idx2, r_idx3;
    t_vec3               r_lo0, r_hi0;
    t_cont               r_cont3;
    logic                r_vis3;
    logic [COUNT_W-1:0]  r_cnt3;
    logic [COUNT_W-1:0]  r_count;

    t_cont               n_cont;
    logic                n_vis;
    logic [COUNT_W-1:0]  n_cnt;
    logic                reject;
    logic                cut;

    fbc_plane_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_plane     (planes)
    );

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        fbc_plane_unit u_plane (
            .i_clk   (i_clk),
            .i_plane (planes[p]),
            .i_lo    (r_lo0),
            .i_hi    (r_hi0),
            .i_en    (en),
            .o_flags (flags[p])
        );
    end

    // stage load enables, back from the output
    assign ld3    = !r_v3 || m_axis_tready;
    assign en.ld2 = !r_v2 || ld3;
    assign en.ld1 = !r_v1 || en.ld2;
    assign ld0    = !r_v0 || en.ld1;
    assign s_axis_tready = ld0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0)    r_v0 <= s_axis_tvalid;
            if (en.ld1) r_v1 <= r_v0;
            if (en.ld2) r_v2 <= r_v1;
            if (ld3)    r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_idx0  <= s_axis_tdata[15:0];
            r_lo0   <= s_axis_tdata[63:16];
            r_hi0   <= s_axis_tdata[111:64];
            r_last0 <= s_axis_tlast;
        end
        if (en.ld1) begin
            r_idx1  <= r_idx0;
            r_last1 <= r_last0;
        end
        if (en.ld2) begin
            r_idx2  <= r_idx1;
            r_last2 <= r_last1;
        end
    end

    always_comb begin
        reject = 1'b0;
        cut    = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            reject = reject | flags[p].all_behind;
            cut    = cut    | flags[p].any_behind;
        end
        if (reject) begin
            n_cont = CONT_NONE;
        end else if (cut) begin
            n_cont = CONT_PARTIAL;
        end else begin
            n_cont = CONT_WHOLE;
        end
        n_vis = !reject;
        n_cnt = (n_vis && r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (ld3 && r_v2) begin
            r_count <= r_last2 ? '0 : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_idx3  <= r_idx2;
            r_cont3 <= n_cont;
            r_vis3  <= n_vis;
            r_cnt3  <= n_cnt;
            r_last3 <= r_last2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tlast  = r_last3;
    assign m_axis_tdata  = {{(OUT_TDATA_W-COORD_W-2-1-COUNT_W){1'b0}},
                            r_cnt3, r_vis3, r_cont3, r_idx3};

    a_vis_matches_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_vis3 == (r_cont3 != CONT_NONE)))
        else $error("visible flag disagrees with containment");

    a_visible_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_vis3) |-> (r_cnt3 != '0))
        else $error("visible box reported with zero count");

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld3 && r_v2 && r_last2) |=> (r_count == '0))
        else $error("running count not cleared after last box");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld3 && r_v2 && !r_last2) |=>
            (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1))
        else $error("running count moved by more than one");

endmodule

`default_nettype wire
